>>> src/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Clocked assertion helpers; compiled out when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
`define AST_HOLDS(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define AST_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);
`else
`define AST_HOLDS(label, prop, msg)
`define AST_NEXT(label, pre, post, msg)
`endif

`endif

>>> src/sled_pkg.sv
// ----------------------------------------------------------------------------
// sled_pkg
// Shared types and constants for the status LED level-to-duty unit.
// ----------------------------------------------------------------------------
package sled_pkg;

  localparam int LEVEL_BITS = 16;
  localparam int DUTY_FULL  = 100;
  localparam int DUTY_W     = 7;
  localparam int MODE_W     = 2;
  localparam int NUM_W      = LEVEL_BITS + DUTY_W;
  localparam int CNT_W      = $clog2(NUM_W);
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = LEVEL_BITS;

  localparam logic [DUTY_W-1:0] DUTY_FULL_C = DUTY_W'(DUTY_FULL);

  localparam logic [MODE_W-1:0] MODE_OFF    = 2'd0;
  localparam logic [MODE_W-1:0] MODE_ON     = 2'd1;
  localparam logic [MODE_W-1:0] MODE_STATUS = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_LED_MODE        = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SHOW_CURRENT    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INTENSITY_STYLE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LEVEL_MIN       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_LEVEL_MAX       = 3'd4;

  localparam logic [LEVEL_BITS-1:0] LEVEL_MAX_RST = LEVEL_BITS'(10000);

  typedef struct packed {
    logic                  output_enabled;
    logic [LEVEL_BITS-1:0] voltage_level;
    logic [LEVEL_BITS-1:0] current_level;
  } in_item_t;

  typedef struct packed {
    logic              fixed_level_drive;
    logic              pin_high;
    logic [DUTY_W-1:0] duty_percent;
    logic              pin_reinit;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CMP,
    ST_MUL,
    ST_DIV,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic capture;
    logic compare;
    logic multiply;
    logic div_step;
    logic load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic skip_div;
  } dp_stat_t;

endpackage

>>> src/sled_ctrl.sv
// ----------------------------------------------------------------------------
// sled_ctrl
// Sequencer: capture, compare, multiply, serial divide if needed, hand off result word.
// ----------------------------------------------------------------------------
module sled_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output sled_pkg::dp_cmd_t cmd,
  input  sled_pkg::dp_stat_t stat
);
  import sled_pkg::*;

  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_CMP;
        end
      end
      ST_CMP: begin
        cmd.compare = 1'b1;
        state_nxt   = ST_MUL;
      end
      ST_MUL: begin
        cmd.multiply = 1'b1;
        cnt_nxt      = CNT_W'(NUM_W - 1);
        state_nxt    = stat.skip_div ? ST_OUT : ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (cnt_r == '0) begin
          state_nxt = ST_OUT;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      ST_OUT: begin
        if (!out_valid_r || out_ready) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

endmodule

>>> src/sled_dpath.sv
// ----------------------------------------------------------------------------
// sled_dpath
// Config registers, level select, range tests, scale multiply, restoring
// divider and result word register.
// ----------------------------------------------------------------------------
module sled_dpath (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [sled_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [sled_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  input  sled_pkg::in_item_t                  in_data,
  output sled_pkg::out_item_t                 out_data,
  input  sled_pkg::dp_cmd_t                   cmd,
  output sled_pkg::dp_stat_t                  stat
);
  import sled_pkg::*;

  // control state
  logic [MODE_W-1:0]     mode_r;
  logic                  show_cur_r;
  logic                  style_r;
  logic [LEVEL_BITS-1:0] lo_r;
  logic [LEVEL_BITS-1:0] hi_r;
  logic [MODE_W-1:0]     prev_mode_r;

  // payload
  logic                  en_r;
  logic [LEVEL_BITS-1:0] lvl_r;
  logic [MODE_W-1:0]     mode_cap_r;
  logic                  reinit_r;
  logic                  direct_r, direct_nxt;
  logic [DUTY_W-1:0]     direct_duty_r, direct_duty_nxt;
  logic                  invert_r;
  logic [LEVEL_BITS-1:0] diff_r, diff_nxt;
  logic [LEVEL_BITS-1:0] span_r, span_nxt;
  logic [NUM_W-1:0]      num_r;
  logic [LEVEL_BITS-1:0] rem_r;
  out_item_t             out_r, out_nxt;

  logic                  invert;
  logic [LEVEL_BITS:0]   trial;
  logic [LEVEL_BITS:0]   trial_sub;
  logic                  qbit;
  logic [DUTY_W-1:0]     quo;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_STATUS;
      show_cur_r  <= 1'b0;
      style_r     <= 1'b1;
      lo_r        <= '0;
      hi_r        <= LEVEL_MAX_RST;
      prev_mode_r <= MODE_STATUS;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_LED_MODE:        mode_r     <= cfg_wdata[MODE_W-1:0];
          CFG_SHOW_CURRENT:    show_cur_r <= cfg_wdata[0];
          CFG_INTENSITY_STYLE: style_r    <= cfg_wdata[0];
          CFG_LEVEL_MIN:       lo_r       <= cfg_wdata[LEVEL_BITS-1:0];
          CFG_LEVEL_MAX:       hi_r       <= cfg_wdata[LEVEL_BITS-1:0];
          default: ;
        endcase
      end
      if (cmd.capture) begin
        prev_mode_r <= mode_r;
      end
    end
  end

  assign invert = (lo_r > hi_r);

  always_comb begin
    diff_nxt        = invert ? (lvl_r - hi_r) : (lvl_r - lo_r);
    span_nxt        = invert ? (lo_r - hi_r) : (hi_r - lo_r);
    direct_nxt      = 1'b1;
    direct_duty_nxt = '0;
    if (mode_cap_r != MODE_STATUS || !en_r) begin
      direct_duty_nxt = '0;
    end else if (!style_r) begin
      if (lo_r == '0 && hi_r != '0) begin
        direct_duty_nxt = (lvl_r < hi_r) ? DUTY_FULL_C : '0;
      end else begin
        direct_duty_nxt = (lvl_r > lo_r) ? DUTY_FULL_C : '0;
      end
    end else if (invert) begin
      if (lvl_r > lo_r) begin
        direct_duty_nxt = '0;
      end else if (lvl_r < hi_r) begin
        direct_duty_nxt = DUTY_FULL_C;
      end else begin
        direct_nxt = 1'b0;
      end
    end else begin
      if (lvl_r > hi_r) begin
        direct_duty_nxt = DUTY_FULL_C;
      end else if (lvl_r < lo_r) begin
        direct_duty_nxt = '0;
      end else if (hi_r == lo_r) begin
        direct_duty_nxt = DUTY_FULL_C;
      end else begin
        direct_nxt = 1'b0;
      end
    end
  end

  // restoring divide, one quotient bit per step
  assign trial     = {rem_r, num_r[NUM_W-1]};
  assign trial_sub = trial - {1'b0, span_r};
  assign qbit      = (trial >= {1'b0, span_r});
  assign quo       = num_r[DUTY_W-1:0];

  always_comb begin
    out_nxt.fixed_level_drive = (mode_cap_r != MODE_STATUS);
    out_nxt.pin_high          = (mode_cap_r != MODE_ON) && (mode_cap_r != MODE_STATUS);
    out_nxt.pin_reinit        = reinit_r;
    if (direct_r) begin
      out_nxt.duty_percent = direct_duty_r;
    end else if (invert_r) begin
      out_nxt.duty_percent = DUTY_FULL_C - quo;
    end else begin
      out_nxt.duty_percent = quo;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      en_r       <= in_data.output_enabled;
      lvl_r      <= show_cur_r ? in_data.current_level : in_data.voltage_level;
      mode_cap_r <= mode_r;
      reinit_r   <= (mode_r != prev_mode_r);
    end
    if (cmd.compare) begin
      direct_r      <= direct_nxt;
      direct_duty_r <= direct_duty_nxt;
      invert_r      <= invert;
      diff_r        <= diff_nxt;
      span_r        <= span_nxt;
    end
    if (cmd.multiply) begin
      num_r <= {{DUTY_W{1'b0}}, diff_r} * {{LEVEL_BITS{1'b0}}, DUTY_FULL_C};
      rem_r <= '0;
    end
    if (cmd.div_step) begin
      rem_r <= qbit ? trial_sub[LEVEL_BITS-1:0] : trial[LEVEL_BITS-1:0];
      num_r <= {num_r[NUM_W-2:0], qbit};
    end
    if (cmd.load_out) begin
      out_r <= out_nxt;
    end
  end

  assign out_data      = out_r;
  assign stat.skip_div = direct_r;

endmodule

>>> src/status_led_level_to_duty_unit.sv
// The serial divide is skipped when no divide is needed; the scaled divide
// uses a 23-step serial restoring divider.
// Throughput: one word at a time; next input word taken the cycle after the
// result is loaded into the output register.
// Reset: synchronous active-low rst_n; config returns to led_mode 2,
// intensity_style 1, level_max 10000, others 0; previous mode 2; no word held.
// ----------------------------------------------------------------------------
// status_led_level_to_duty_unit
// Turns analog output state into a status LED pin drive and PWM duty.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module status_led_level_to_duty_unit (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [sled_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [sled_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  sled_pkg::in_item_t               in_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output sled_pkg::out_item_t              out_data
);
  import sled_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  sled_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  sled_dpath u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_data   (in_data),
    .out_data  (out_data),
    .cmd       (cmd),
    .stat      (stat)
  );

  `AST_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "accepted word did not mark busy")
  `AST_HOLDS(a_duty_range, !out_valid || out_data.duty_percent <= DUTY_FULL_C, "duty above full")
  `AST_HOLDS(a_fixed_no_duty, !out_valid || !out_data.fixed_level_drive || out_data.duty_percent == '0, "duty set on fixed drive")

endmodule

>>> tb/sled_duty_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sled_duty_checker
// Watches the config port and both word channels of the status LED unit,
// predicts each result word from its own mirror of the registers and of the
// previous mode, and compares accepted result words in order, field by field.
// ----------------------------------------------------------------------------
module sled_duty_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [sled_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sled_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                            in_valid,
  input  logic                            in_ready,
  input  sled_pkg::in_item_t              in_data,
  input  logic                            out_valid,
  input  logic                            out_ready,
  input  sled_pkg::out_item_t             out_data,
  output int                              fail_count,
  output int                              pending
);
  import sled_pkg::*;

  logic [MODE_W-1:0]     mode_q;
  logic [MODE_W-1:0]     prev_mode_q;
  logic                  show_cur_q;
  logic                  scaled_q;
  logic [LEVEL_BITS-1:0] lo_q;
  logic [LEVEL_BITS-1:0] hi_q;
  out_item_t             expected_drive_q[$];

  task automatic report_mismatch(input string what, input int exp_v, input int got_v);
    fail_count++;
    $display("mismatch: %s expected %0d got %0d at %0t", what, exp_v, got_v, $time);
  endtask

  function automatic logic [DUTY_W-1:0] threshold_duty(input int unsigned v,
                                                       input int unsigned lo,
                                                       input int unsigned hi);
    if (lo == 0 && hi > 0) begin
      return (v < hi) ? DUTY_FULL_C : '0;
    end
    return (v > lo) ? DUTY_FULL_C : '0;
  endfunction

  function automatic logic [DUTY_W-1:0] scaled_duty(input int unsigned v,
                                                    input int unsigned lo,
                                                    input int unsigned hi);
    int unsigned span;
    if (lo > hi) begin
      if (v > lo) return '0;
      if (v < hi) return DUTY_FULL_C;
      span = lo - hi;
      return DUTY_W'(DUTY_FULL - ((v - hi) * DUTY_FULL) / span);
    end
    if (v > hi) return DUTY_FULL_C;
    if (v < lo) return '0;
    span = hi - lo;
    if (span == 0) return DUTY_FULL_C;
    return DUTY_W'(((v - lo) * DUTY_FULL) / span);
  endfunction

  function automatic out_item_t predict_drive(input in_item_t w);
    out_item_t   r;
    int unsigned lvl;
    r.fixed_level_drive = 1'b1;
    r.pin_high          = 1'b1;
    r.duty_percent      = '0;
    r.pin_reinit        = (mode_q != prev_mode_q);
    if (mode_q == MODE_ON) begin
      r.pin_high = 1'b0;
    end else if (mode_q == MODE_STATUS) begin
      r.fixed_level_drive = 1'b0;
      r.pin_high          = 1'b0;
      if (w.output_enabled) begin
        lvl = 32'(show_cur_q ? w.current_level : w.voltage_level);
        r.duty_percent = scaled_q ? scaled_duty(lvl, 32'(lo_q), 32'(hi_q))
                                  : threshold_duty(lvl, 32'(lo_q), 32'(hi_q));
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin
    out_item_t e;
    if (!rst_n) begin
      mode_q      = MODE_STATUS;
      prev_mode_q = MODE_STATUS;
      show_cur_q  = 1'b0;
      scaled_q    = 1'b1;
      lo_q        = '0;
      hi_q        = LEVEL_MAX_RST;
      expected_drive_q.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (expected_drive_q.size() == 0) begin
          report_mismatch("word with nothing expected", 0, int'(out_data));
        end else begin
          e = expected_drive_q.pop_front();
          if (out_data.fixed_level_drive !== e.fixed_level_drive)
            report_mismatch("fixed_level_drive", int'(e.fixed_level_drive),
                            int'(out_data.fixed_level_drive));
          if (out_data.pin_high !== e.pin_high)
            report_mismatch("pin_high", int'(e.pin_high), int'(out_data.pin_high));
          if (out_data.duty_percent !== e.duty_percent)
            report_mismatch("duty_percent", int'(e.duty_percent),
                            int'(out_data.duty_percent));
          if (out_data.pin_reinit !== e.pin_reinit)
            report_mismatch("pin_reinit", int'(e.pin_reinit), int'(out_data.pin_reinit));
        end
      end
      if (in_valid && in_ready) begin
        expected_drive_q.push_back(predict_drive(in_data));
        prev_mode_q = mode_q;
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_LED_MODE:        mode_q     = cfg_wdata[MODE_W-1:0];
          CFG_SHOW_CURRENT:    show_cur_q = cfg_wdata[0];
          CFG_INTENSITY_STYLE: scaled_q   = cfg_wdata[0];
          CFG_LEVEL_MIN:       lo_q       = cfg_wdata[LEVEL_BITS-1:0];
          CFG_LEVEL_MAX:       hi_q       = cfg_wdata[LEVEL_BITS-1:0];
          default: ;
        endcase
      end
    end
    pending = expected_drive_q.size();
  end

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the status LED level-to-duty unit: a directed set
// of modes, thresholds, inverted and zero spans, then random config phases
// with random levels, random input gaps and output stalls.
// ----------------------------------------------------------------------------
module tb_top;
  import sled_pkg::*;

  localparam int LIMIT_CYCLES  = 600000;
  localparam int SETTLE_CYCLES = 30;
  localparam int RAND_PHASES   = 31;
  localparam int WORDS_PER_PH  = 50;
  localparam int LEVEL_TOP     = (1 << LEVEL_BITS) - 1;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  in_valid  = 1'b0;
  logic                  in_ready;
  in_item_t              in_data   = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_item_t             out_data;
  logic                  quiet     = 1'b0;
  int                    fail_count;
  int                    pending;
  int                    cycles    = 0;

  status_led_level_to_duty_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  sled_duty_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_ready <= quiet ? 1'b1 : ($urandom_range(99) >= 31);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("FAILURE");
      $finish;
    end
  end

  function automatic int clamp_level(input int x);
    if (x < 0) return 0;
    if (x > LEVEL_TOP) return LEVEL_TOP;
    return x;
  endfunction

  function automatic in_item_t mk_word(input logic en, input int v, input int c);
    in_item_t w;
    w.output_enabled = en;
    w.voltage_level  = LEVEL_BITS'(v);
    w.current_level  = LEVEL_BITS'(c);
    return w;
  endfunction

  // Mostly levels inside or at the edges of the configured window.
  function automatic int pick_level(input int lo, input int hi);
    int a;
    int b;
    a = (lo < hi) ? lo : hi;
    b = (lo < hi) ? hi : lo;
    case ($urandom_range(7))
      0, 1, 2, 3: return int'($urandom_range(b, a));
      4:          return clamp_level(lo + int'($urandom_range(2)) - 1);
      5:          return clamp_level(hi + int'($urandom_range(2)) - 1);
      6:          return int'($urandom_range(LEVEL_TOP));
      default:    return $urandom_range(1) ? LEVEL_TOP : 0;
    endcase
  endfunction

  function automatic in_item_t random_word(input int lo, input int hi);
    return mk_word($urandom_range(99) < 85, pick_level(lo, hi), pick_level(lo, hi));
  endfunction

  task automatic send_word(input in_item_t w);
    while (!quiet && $urandom_range(99) < 31) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= d;
    @(posedge clk);
  endtask

  // Unused upper bits of the narrow registers carry junk.
  task automatic load_config(input logic [MODE_W-1:0] mode, input logic sc,
                             input logic style, input int lo, input int hi);
    logic [CFG_DATA_W-1:0] d;
    d = CFG_DATA_W'($urandom);
    d[MODE_W-1:0] = mode;
    write_reg(CFG_LED_MODE, d);
    d = CFG_DATA_W'($urandom);
    d[0] = sc;
    write_reg(CFG_SHOW_CURRENT, d);
    d = CFG_DATA_W'($urandom);
    d[0] = style;
    write_reg(CFG_INTENSITY_STYLE, d);
    write_reg(CFG_LEVEL_MIN, CFG_DATA_W'(lo));
    write_reg(CFG_LEVEL_MAX, CFG_DATA_W'(hi));
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    logic [MODE_W-1:0] mode;
    int                lo;
    int                hi;
    int                ph;
    int                i;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset config: scaled, voltage, 0..10000
    send_word(mk_word(1'b1, 5000, 0));
    send_word(mk_word(1'b0, 5000, LEVEL_TOP));
    send_word(mk_word(1'b1, LEVEL_TOP, 0));

    // each mode code in turn, including the unused mode code
    for (i = 0; i < 4; i++) begin
      settle();
      load_config(MODE_W'(i), 1'b0, 1'b1, 0, 10000);
      send_word(mk_word(1'b1, 7000, 7000));
    end
    send_word(mk_word(1'b1, 7000, 7000));

    // threshold below max, then above min
    settle();
    load_config(MODE_STATUS, 1'b0, 1'b0, 0, 1000);
    send_word(mk_word(1'b1, 999, 0));
    send_word(mk_word(1'b1, 1000, 0));
    settle();
    load_config(MODE_STATUS, 1'b0, 1'b0, 500, 0);
    send_word(mk_word(1'b1, 501, 0));
    send_word(mk_word(1'b1, 500, 0));
    settle();
    load_config(MODE_STATUS, 1'b0, 1'b0, 0, 0);
    send_word(mk_word(1'b1, 0, LEVEL_TOP));
    send_word(mk_word(1'b1, LEVEL_TOP, 0));

    // inverted scaling on current
    settle();
    load_config(MODE_STATUS, 1'b1, 1'b1, 60000, 10000);
    send_word(mk_word(1'b1, 0, 35000));
    send_word(mk_word(1'b1, 0, LEVEL_TOP));
    send_word(mk_word(1'b1, LEVEL_TOP, 0));

    // zero span
    settle();
    load_config(MODE_STATUS, 1'b0, 1'b1, 30000, 30000);
    send_word(mk_word(1'b1, 30001, 0));
    send_word(mk_word(1'b1, 29999, 0));
    send_word(mk_word(1'b1, 30000, 0));

    // full range
    settle();
    load_config(MODE_STATUS, 1'b0, 1'b1, 0, LEVEL_TOP);
    send_word(mk_word(1'b1, LEVEL_TOP, 0));
    send_word(mk_word(1'b1, 1, 0));
    send_word(mk_word(1'b1, 0, LEVEL_TOP));

    for (ph = 0; ph < RAND_PHASES; ph++) begin
      settle();
      quiet <= (ph >= 12 && ph < 17);
      mode = ($urandom_range(9) < 6) ? MODE_STATUS : MODE_W'($urandom_range(3));
      case ($urandom_range(5))
        0: begin
          lo = int'($urandom_range(LEVEL_TOP));
          hi = int'($urandom_range(LEVEL_TOP));
        end
        1: begin
          lo = int'($urandom_range(LEVEL_TOP));
          hi = clamp_level(lo + int'($urandom_range(300)));
        end
        2: begin
          hi = int'($urandom_range(LEVEL_TOP - 1));
          lo = clamp_level(hi + 1 + int'($urandom_range(LEVEL_TOP)));
        end
        3: begin
          lo = int'($urandom_range(LEVEL_TOP));
          hi = lo;
        end
        4: begin
          lo = $urandom_range(1) ? LEVEL_TOP : 0;
          hi = $urandom_range(1) ? LEVEL_TOP : 0;
        end
        default: begin
          lo = 0;
          hi = int'($urandom_range(LEVEL_TOP));
        end
      endcase
      load_config(mode, 1'($urandom_range(1)), 1'($urandom_range(1)), lo, hi);
      for (i = 0; i < WORDS_PER_PH; i++) begin
        send_word(random_word(lo, hi));
      end
    end

    settle();
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+src
src/sled_pkg.sv
src/sled_ctrl.sv
src/sled_dpath.sv
src/status_led_level_to_duty_unit.sv
tb/sled_duty_checker.sv
tb/tb_top.sv
